// ----- design/bkvs_pkg.sv -----
// ----------------------------------------------------------------------------
// bkvs_pkg
// Types and constants shared by the bounded key/value store and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bkvs_pkg;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;
	localparam int CAP_W   = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic               found;
		logic [VALUE_W-1:0] found_value;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEL
	} state_t;

	// per-cell controls from the sequencer
	typedef struct packed {
		logic cmp;
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage : bkvs_pkg

`default_nettype wire

// ----- design/bounded_key_value_store_top.sv -----
// ----------------------------------------------------------------------------
// bounded_key_value_store_top
// Bounded associative store built as a row of cells kept packed oldest first.
// ----------------------------------------------------------------------------
// Each operation walks ST_IDLE, ST_CMP and ST_SEL: the beat is taken in ST_IDLE,
// every cell compares its key in ST_CMP, and in ST_SEL the newest hit is
// chosen, the result is registered and an add loads the first empty cell or a
// remove shifts the newer cells down by one. No new beat is taken until the
// last one has committed; a result held by rsp_stall holds the commit cycle.
// The capacity register may be written whenever no operation is in flight;
// cfg_ready is always high.
`default_nettype none

module bounded_key_value_store_top
	import bkvs_pkg::*;
#(
	parameter int ENTRIES    = 32,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	localparam int VB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int WW = (CW > CAP_W) ? CW : CAP_W;

	state_t state_q, state_d;

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VB-1:0]       value_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       count_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	cell_ctrl_t    ctrl    [ENTRIES];
	logic [KEY_BITS-1:0] c_key [ENTRIES];
	logic [VB-1:0] c_value [ENTRIES];
	logic [ENTRIES-1:0] c_valid;
	logic [ENTRIES-1:0] c_hit;
	logic [ENTRIES-1:0] first_empty;
	logic [ENTRIES-1:0] at_or_above;
	logic               any_hit;
	logic [VB-1:0]      hit_value;

	logic accept, commit, room, add_ok, rem_ok, lookup_op;
	logic [CW-1:0] count_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_SEL;
			end
			ST_SEL: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			key_q   <= req.key[KEY_BITS-1:0];
			value_q <= req.value[VB-1:0];
		end
	end

	assign room      = (WW'(count_q) < WW'(cap_q)) && (count_q < CW'(ENTRIES));
	assign add_ok    = (op_q == OP_ADD) && (value_q != '0) && room;
	assign rem_ok    = (op_q == OP_REMOVE) && any_hit;
	assign lookup_op = (op_q == OP_LOOKUP);

	always_comb begin
		priority if (add_ok) begin
			count_d = count_q + CW'(1);
		end else if (rem_ok) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.ok          <= add_ok || rem_ok;
			rsp_q.found       <= (lookup_op || rem_ok) && any_hit;
			rsp_q.found_value <= ((lookup_op || rem_ok) && any_hit) ?
			                     VALUE_W'(hit_value) : '0;
			rsp_q.entry_count <= COUNT_W'(count_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// row of cells, each fed by its upper neighbor
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0] nb_key;
		logic [VB-1:0]       nb_value;
		logic                nb_valid;

		if (i == ENTRIES - 1) begin : g_top
			assign nb_key   = '0;
			assign nb_value = '0;
			assign nb_valid = 1'b0;
		end else begin : g_mid
			assign nb_key   = c_key[i+1];
			assign nb_value = c_value[i+1];
			assign nb_valid = c_valid[i+1];
		end

		if (i == 0) begin : g_first
			assign first_empty[i] = !c_valid[i];
		end else begin : g_rest
			assign first_empty[i] = !c_valid[i] && c_valid[i-1];
		end

		assign ctrl[i].cmp   = (state_q == ST_CMP);
		assign ctrl[i].load  = commit && add_ok && first_empty[i];
		assign ctrl[i].shift = commit && rem_ok && at_or_above[i];

		bkvs_cell #(
			.KB (KEY_BITS),
			.VB (VB)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.cmp_key   (key_q),
			.new_value (value_q),
			.nb_key    (nb_key),
			.nb_value  (nb_value),
			.nb_valid  (nb_valid),
			.key       (c_key[i]),
			.value     (c_value[i]),
			.valid     (c_valid[i]),
			.hit       (c_hit[i])
		);
	end

	bkvs_select #(
		.N  (ENTRIES),
		.VB (VB)
	) u_select (
		.hit         (c_hit),
		.value       (c_value),
		.any_hit     (any_hit),
		.at_or_above (at_or_above),
		.hit_value   (hit_value)
	);

endmodule : bounded_key_value_store_top

`default_nettype wire

// ----- design/bkvs_cell.sv -----
// ----------------------------------------------------------------------------
// bkvs_cell
// One storage cell: holds a key, a value and a valid flag, compares against
// the lookup key and takes its upper neighbor's contents on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bkvs_cell
	import bkvs_pkg::*;
#(
	parameter int KB = 64,
	parameter int VB = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctrl_t    ctrl,
	input  wire logic [KB-1:0] cmp_key,
	input  wire logic [VB-1:0] new_value,
	input  wire logic [KB-1:0] nb_key,
	input  wire logic [VB-1:0] nb_value,
	input  wire logic          nb_valid,
	output logic      [KB-1:0] key,
	output logic      [VB-1:0] value,
	output logic               valid,
	output logic               hit
);

	logic [KB-1:0] key_q;
	logic [VB-1:0] value_q;
	logic          valid_q;
	logic          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				hit_q <= valid_q && (key_q == cmp_key);
			end
			if (ctrl.load) begin
				valid_q <= 1'b1;
			end else if (ctrl.shift) begin
				valid_q <= nb_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= cmp_key;
			value_q <= new_value;
		end else if (ctrl.shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule : bkvs_cell

`default_nettype wire

// ----- design/bkvs_select.sv -----
// ----------------------------------------------------------------------------
// bkvs_select
// Picks the newest matching cell from the hit flags, marks the cells that
// shift down on a remove and gathers the value of the chosen cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bkvs_select
	import bkvs_pkg::*;
#(
	parameter int N  = 32,
	parameter int VB = 32
) (
	input  wire logic [N-1:0]  hit,
	input  wire logic [VB-1:0] value [N],
	output logic               any_hit,
	output logic      [N-1:0]  at_or_above,
	output logic      [VB-1:0] hit_value
);

	logic [N-1:0] sel;

	// a cell is at or above the newest hit when no hit lies strictly above it
	always_comb begin
		for (int i = 0; i < N; i++) begin
			at_or_above[i] = (|hit) && !(|(hit >> (i + 1)));
			sel[i]         = hit[i] && !(|(hit >> (i + 1)));
		end
	end

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < N; i++) begin
			hit_value = hit_value | (sel[i] ? value[i] : '0);
		end
	end

	assign any_hit = |hit;

endmodule : bkvs_select

`default_nettype wire

// ----- tb/bounded_key_value_store_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_key_value_store_top_test
// Self-checking bench for the bounded key/value store.
// ----------------------------------------------------------------------------
// A short scripted run covers the empty store, zero values, duplicate keys,
// the unused op code and the capacity extremes. Random phases follow with
// their own capacity and idle pattern. Every answer is compared field by
// field with the scripted answer, or else with the bench's shadow store.

module bounded_key_value_store_top_test;
	import bkvs_pkg::*;

	localparam int ENTRIES = 32;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct {
		bit               is_cap;
		logic [CAP_W-1:0] cap;
		req_t             beat;
		bit               typed;
		rsp_t             answer;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	// shadow copy of the store, oldest entry at slot 0
	logic [KEY_W-1:0]   shadow_key [ENTRIES];
	logic [VALUE_W-1:0] shadow_value [ENTRIES];
	int unsigned        shadow_count;
	logic [CAP_W-1:0]   shadow_cap;

	rsp_t        owed_answers [$];
	script_row_t script_q [$];
	bit          fault_seen = 1'b0;
	int          req_gap_pct = 0;
	int          rsp_stall_pct = 0;
	int          hold_order = 0;
	int          hold_left = 0;
	int          idle_run = 0;

	bounded_key_value_store_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int newest_slot(input logic [KEY_W-1:0] key);
		for (int i = int'(shadow_count) - 1; i >= 0; i--) begin
			if (shadow_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	function automatic rsp_t apply_to_shadow(input req_t b);
		rsp_t        a;
		int          hit;
		int unsigned ceiling;
		a = '0;
		ceiling = (shadow_cap > ENTRIES) ? ENTRIES : shadow_cap;
		case (b.op)
			OP_ADD: begin
				if (b.value != '0 && shadow_count < ceiling) begin
					shadow_key[shadow_count] = b.key;
					shadow_value[shadow_count] = b.value;
					shadow_count++;
					a.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				hit = newest_slot(b.key);
				if (hit >= 0) begin
					a.found = 1'b1;
					a.found_value = shadow_value[hit];
				end
			end
			OP_REMOVE: begin
				hit = newest_slot(b.key);
				if (hit >= 0) begin
					a.ok = 1'b1;
					a.found = 1'b1;
					a.found_value = shadow_value[hit];
					// newer entries slide down one slot
					for (int i = hit; i + 1 < int'(shadow_count); i++) begin
						shadow_key[i] = shadow_key[i + 1];
						shadow_value[i] = shadow_value[i + 1];
					end
					shadow_count--;
				end
			end
			default: ;
		endcase
		a.entry_count = shadow_count[COUNT_W-1:0];
		return a;
	endfunction

	function automatic script_row_t known(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value,
			input logic ok, input logic found, input logic [VALUE_W-1:0] fval,
			input logic [COUNT_W-1:0] count);
		script_row_t r;
		r.is_cap = 1'b0;
		r.cap = '0;
		r.beat = '{op: op, key: key, value: value};
		r.typed = 1'b1;
		r.answer = '{ok: ok, found: found, found_value: fval, entry_count: count};
		return r;
	endfunction

	function automatic script_row_t checked(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value);
		script_row_t r;
		r = known(op, key, value, 1'b0, 1'b0, '0, '0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic script_row_t cap_write(input logic [CAP_W-1:0] c);
		script_row_t r;
		r = checked(OP_NONE, '0, '0);
		r.is_cap = 1'b1;
		r.cap = c;
		return r;
	endfunction

	// capacity is only written once every answer is back
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		req_valid <= 1'b0;
		while (owed_answers.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_cap = c;
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_beat(input req_t b, input bit typed, input rsp_t typed_answer);
		rsp_t a;
		if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < req_gap_pct);
		end
		req_valid <= 1'b1;
		req <= b;
		do
			@(posedge clk);
		while (req_stall);
		a = apply_to_shadow(b);
		owed_answers.push_back(typed ? typed_answer : a);
	endtask

	task automatic random_phase(input logic [CAP_W-1:0] cap, input int gap_pct,
			input int stall_pct, input int add_pct, input int remove_pct,
			input int items, input int hold);
		logic [KEY_W-1:0] pool [8];
		req_t             b;
		int               pick;
		write_capacity(cap);
		req_gap_pct = gap_pct;
		rsp_stall_pct = stall_pct;
		hold_order = hold;
		// a small key pool so that lookups and removes hit and duplicates pile up
		foreach (pool[i])
			pool[i] = {$urandom, $urandom};
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < add_pct)
				b.op = OP_ADD;
			else if (pick < add_pct + remove_pct)
				b.op = OP_REMOVE;
			else if (pick < 97)
				b.op = OP_LOOKUP;
			else
				b.op = OP_NONE;
			b.key = ($urandom_range(99) < 80) ? pool[$urandom_range(7)] : {$urandom, $urandom};
			b.value = ($urandom_range(99) < 5) ? '0 : $urandom;
			offer_beat(b, 1'b0, '0);
		end
	endtask

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_order != 0) begin
			hold_left = hold_order;
			hold_order = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_answers.size() == 0) begin
				$display("%0t: unexpected answer beat %p", $time, rsp);
				fault_seen = 1'b1;
			end else begin
				want = owed_answers.pop_front();
				if (rsp.ok !== want.ok) begin
					$display("%0t: ok expected %0b got %0b", $time, want.ok, rsp.ok);
					fault_seen = 1'b1;
				end
				if (rsp.found !== want.found) begin
					$display("%0t: found expected %0b got %0b", $time, want.found, rsp.found);
					fault_seen = 1'b1;
				end
				if (rsp.found_value !== want.found_value) begin
					$display("%0t: found_value expected %h got %h", $time,
						want.found_value, rsp.found_value);
					fault_seen = 1'b1;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d got %0d", $time,
						want.entry_count, rsp.entry_count);
					fault_seen = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("bounded_key_value_store_top regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		shadow_count = 0;
		shadow_cap = CAP_RESET;

		script_q.push_back(known(OP_LOOKUP, 64'h0, 32'h0, 0, 0, 32'h0, 0));
		script_q.push_back(known(OP_REMOVE, '1, 32'h0, 0, 0, 32'h0, 0));
		script_q.push_back(known(OP_ADD, 64'h0, 32'h0, 0, 0, 32'h0, 0));
		script_q.push_back(known(OP_ADD, 64'h0, 32'hffff_ffff, 1, 0, 32'h0, 1));
		script_q.push_back(known(OP_ADD, '1, 32'h1, 1, 0, 32'h0, 2));
		script_q.push_back(known(OP_ADD, '1, 32'h2, 1, 0, 32'h0, 3));
		script_q.push_back(known(OP_LOOKUP, '1, 32'h0, 0, 1, 32'h2, 3));
		script_q.push_back(known(OP_REMOVE, '1, 32'h0, 1, 1, 32'h2, 2));
		script_q.push_back(known(OP_LOOKUP, '1, 32'h0, 0, 1, 32'h1, 2));
		script_q.push_back(known(OP_LOOKUP, 64'h0, '1, 0, 1, 32'hffff_ffff, 2));
		script_q.push_back(known(OP_NONE, 64'h0, 32'h5, 0, 0, 32'h0, 2));
		script_q.push_back(known(OP_REMOVE, 64'h0, 32'h0, 1, 1, 32'hffff_ffff, 1));
		script_q.push_back(checked(OP_LOOKUP, '1, 32'h0));
		script_q.push_back(known(OP_REMOVE, '1, 32'h0, 1, 1, 32'h1, 0));
		script_q.push_back(cap_write(6'd1));
		script_q.push_back(known(OP_ADD, 64'h0123_4567_89ab_cdef, 32'h8000_0000, 1, 0, 32'h0, 1));
		script_q.push_back(known(OP_ADD, 64'h5, 32'h7, 0, 0, 32'h0, 1));
		// capacity drops below the count: entries stay, adds fail
		script_q.push_back(cap_write(6'd0));
		script_q.push_back(known(OP_ADD, 64'h5, 32'h7, 0, 0, 32'h0, 1));
		script_q.push_back(known(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 32'h0, 0, 1, 32'h8000_0000, 1));
		script_q.push_back(checked(OP_LOOKUP, 64'h0123_4567_89ab_cdee, 32'h0));
		script_q.push_back(cap_write(6'd63));
		script_q.push_back(known(OP_ADD, 64'h5, 32'h7, 1, 0, 32'h0, 2));
		script_q.push_back(known(OP_REMOVE, 64'h5, 32'h0, 1, 1, 32'h7, 1));
		script_q.push_back(known(OP_REMOVE, 64'h5, 32'h0, 0, 0, 32'h0, 1));

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_q[i]) begin
			if (script_q[i].is_cap)
				write_capacity(script_q[i].cap);
			else
				offer_beat(script_q[i].beat, script_q[i].typed, script_q[i].answer);
		end

		random_phase(6'd63, 0, 0, 60, 20, 250, 0);
		random_phase(6'd32, 57, 0, 45, 30, 250, 0);
		random_phase(6'd5, 0, 57, 45, 30, 250, 0);
		random_phase(6'd1, 27, 27, 45, 30, 200, 0);
		// long receiver hold-off while beats keep coming
		random_phase(6'd20, 0, 0, 50, 25, 180, 400);
		random_phase(6'd0, 27, 27, 35, 45, 150, 0);

		req_valid <= 1'b0;
		while (owed_answers.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (!fault_seen)
			$display("bounded_key_value_store_top regression: pass");
		else
			$display("bounded_key_value_store_top regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bkvs_pkg.sv
design/bkvs_cell.sv
design/bkvs_select.sv
design/bounded_key_value_store_top.sv
tb/bounded_key_value_store_top_test.sv
